@@ sv/dcu_pkg.sv @@
package dcu_pkg;

    // Default width of the value field.
    localparam int VALUE_WIDTH_DEF = 20;

    // Width and saturation limit of the divisor count field.
    localparam int COUNT_WIDTH = 8;
    localparam int COUNT_MAX   = 255;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_STEP,
        ST_FINISH
    } t_state;

endpackage

@@ sv/divisor_counter_unit.sv @@
// Divisor counter: each input beat carries one positive integer and produces
// one output beat with its number of positive divisors (tau). The value is
// factored by trial division with candidates 2, 3, 4, ... generated inside
// the block. Every trial is a bit-serial restoring division of VALUE_WIDTH
// steps in ST_DIV plus one evaluation step in ST_STEP, and the quotient of that
// same division decides when the candidate has passed the square root of
// what is left to factor. One item therefore needs about
// floor(sqrt(value)) + (number of prime factors) trials: a prime near 2^20
// is among the costliest, a highly composite value far cheaper, and a zero
// input goes straight to ST_FINISH with a count of zero as an error code.
// Counts above 255 saturate, which cannot happen at the default width of
// 20 bits. The block works on one item at a time and holds o_stall high
// while it does; a finished count sits in the output register until it is
// taken, and the next input beat is accepted as soon as the count has
// moved there.
module divisor_counter_unit #(
    parameter int VALUE_WIDTH = dcu_pkg::VALUE_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [VALUE_WIDTH-1:0]         i_value,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [dcu_pkg::COUNT_WIDTH-1:0] o_divisor_count
);

    import dcu_pkg::*;

    // Exponent counter must hold VALUE_WIDTH, the largest exponent plus one.
    localparam int EXP_WIDTH  = $clog2(VALUE_WIDTH + 1);
    localparam int CNT_WIDTH  = $clog2(VALUE_WIDTH);
    localparam int MULT_WIDTH = COUNT_WIDTH + EXP_WIDTH;

    t_state                  r_state, n_state;
    logic [VALUE_WIDTH-1:0]  r_m, n_m;          // part of the value still to factor
    logic [VALUE_WIDTH-1:0]  r_d, n_d;          // trial divisor
    logic [VALUE_WIDTH-1:0]  r_a, n_a;          // dividend in, quotient out
    logic [VALUE_WIDTH:0]    r_rem, n_rem;      // partial remainder
    logic [CNT_WIDTH-1:0]    r_cnt, n_cnt;
    logic [EXP_WIDTH-1:0]    r_exp, n_exp;
    logic [COUNT_WIDTH-1:0]  r_prod, n_prod;
    logic                    r_o_valid, n_o_valid;
    logic [COUNT_WIDTH-1:0]  r_o_count, n_o_count;

    logic [VALUE_WIDTH:0]    trial;
    logic                    trial_ge;
    logic [EXP_WIDTH-1:0]    factor;
    logic [MULT_WIDTH-1:0]   mult;
    logic [COUNT_WIDTH-1:0]  sat_prod;
    logic                    out_free;

    // One step of the restoring division: bring down the next dividend bit
    // and subtract the divisor when it fits.
    assign trial    = {r_rem[VALUE_WIDTH-1:0], r_a[VALUE_WIDTH-1]};
    assign trial_ge = (trial >= {1'b0, r_d});

    // The running product only ever grows, so saturating each multiply gives
    // the same result as saturating the final count.
    assign factor   = (r_exp == '0) ? EXP_WIDTH'(2) : r_exp + EXP_WIDTH'(1);
    assign mult     = MULT_WIDTH'(r_prod) * MULT_WIDTH'(factor);
    assign sat_prod = (mult > MULT_WIDTH'(COUNT_MAX)) ? COUNT_WIDTH'(COUNT_MAX)
                                                      : mult[COUNT_WIDTH-1:0];

    assign out_free = !r_o_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_o_valid <= n_o_valid;
        end
        r_m       <= n_m;
        r_d       <= n_d;
        r_a       <= n_a;
        r_rem     <= n_rem;
        r_cnt     <= n_cnt;
        r_exp     <= n_exp;
        r_prod    <= n_prod;
        r_o_count <= n_o_count;
    end

    always_comb begin
        n_state   = r_state;
        n_m       = r_m;
        n_d       = r_d;
        n_a       = r_a;
        n_rem     = r_rem;
        n_cnt     = r_cnt;
        n_exp     = r_exp;
        n_prod    = r_prod;
        n_o_count = r_o_count;
        n_o_valid = r_o_valid && i_stall;

        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_m    = i_value;
                    n_d    = VALUE_WIDTH'(2);
                    n_a    = i_value;
                    n_rem  = '0;
                    n_cnt  = '0;
                    n_exp  = '0;
                    n_prod = COUNT_WIDTH'(1);
                    if (i_value == '0) begin
                        // Zero has no finite divisor count.
                        n_prod  = '0;
                        n_state = ST_FINISH;
                    end else begin
                        n_state = ST_DIV;
                    end
                end
            end

            ST_DIV: begin
                n_rem = trial_ge ? (trial - {1'b0, r_d}) : trial;
                n_a   = {r_a[VALUE_WIDTH-2:0], trial_ge};
                n_cnt = r_cnt + CNT_WIDTH'(1);
                if (r_cnt == CNT_WIDTH'(VALUE_WIDTH - 1)) begin
                    n_state = ST_STEP;
                end
            end

            ST_STEP: begin
                // Here r_a holds the quotient and r_rem the remainder.
                n_rem   = '0;
                n_cnt   = '0;
                n_state = ST_DIV;
                if (r_exp == '0) begin
                    if (r_d > r_a) begin
                        // The divisor has passed the square root of what is
                        // left, so any remainder above one is a single prime.
                        if (r_m > VALUE_WIDTH'(1)) begin
                            n_prod = sat_prod;
                        end
                        n_state = ST_FINISH;
                    end else if (r_rem == '0) begin
                        n_m   = r_a;
                        n_a   = r_a;
                        n_exp = EXP_WIDTH'(1);
                    end else begin
                        n_d = r_d + VALUE_WIDTH'(1);
                        n_a = r_m;
                    end
                end else begin
                    if (r_rem == '0) begin
                        n_m   = r_a;
                        n_a   = r_a;
                        n_exp = r_exp + EXP_WIDTH'(1);
                    end else begin
                        // The exponent of this divisor is complete.
                        n_prod = sat_prod;
                        n_exp  = '0;
                        n_d    = r_d + VALUE_WIDTH'(1);
                        n_a    = r_m;
                    end
                end
            end

            ST_FINISH: begin
                if (out_free) begin
                    n_o_valid = 1'b1;
                    n_o_count = r_prod;
                    n_state   = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_stall         = (r_state != ST_IDLE);
    assign o_valid         = r_o_valid;
    assign o_divisor_count = r_o_count;

endmodule

@@ sv/dcu_checker.sv @@
module dcu_checker #(
    parameter int VALUE_WIDTH = dcu_pkg::VALUE_WIDTH_DEF
) (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_valid,
    input logic                            o_stall,
    input logic [VALUE_WIDTH-1:0]          i_value,
    input logic                            o_valid,
    input logic                            i_stall,
    input logic [dcu_pkg::COUNT_WIDTH-1:0] o_divisor_count
);

    // An accepted beat always leaves the block busy in the cycle after it.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("block did not go busy after an input beat");

    // A new result only appears at the end of a busy period.
    a_result_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($rose(o_valid) && $past(i_rst_n)) |-> ($past(o_stall) && !o_stall))
        else $error("result appeared without a finished item");

    // The block leaves its busy period only with a result in the output register.
    a_idle_with_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($fell(o_stall) && $past(i_rst_n)) |-> o_valid)
        else $error("block went idle without presenting a result");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_divisor_count)))
        else $error("stalled output beat changed");

    // A stalled input beat holds.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_stall) |=> (i_valid && $stable(i_value)))
        else $error("stalled input beat changed");

endmodule

bind divisor_counter_unit dcu_checker #(.VALUE_WIDTH(VALUE_WIDTH)) u_dcu_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_valid         (i_valid),
    .o_stall         (o_stall),
    .i_value         (i_value),
    .o_valid         (o_valid),
    .i_stall         (i_stall),
    .o_divisor_count (o_divisor_count)
);
